// File: rtl/blle_pkg.sv
`default_nettype none

package blle_pkg;

   // payload field widths
   localparam int OPCODE_W = 3;
   localparam int VALUE_W  = 64;
   localparam int NODE_W   = 6;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic [OPCODE_W-1:0] OP_INSERT_HEAD = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_INSERT_TAIL = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_HEAD = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_TAIL = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_NODE = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY       = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_IN_LIST = 2'd3;

   // reset value of the list limit register
   localparam logic [COUNT_W-1:0] LIST_LIMIT_RESET = 7'd64;

   typedef logic signed [VALUE_W-1:0] value_type;

endpackage

`default_nettype wire

// File: rtl/blle_req_if.sv
`default_nettype none

interface blle_req_if import blle_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   value_type           item_value;
   logic [NODE_W-1:0]   node_index;

   modport source (output valid, output opcode, output item_value, output node_index,
                   input ready);
   modport sink   (input valid, input opcode, input item_value, input node_index,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/blle_rsp_if.sv
`default_nettype none

interface blle_rsp_if import blle_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [NODE_W-1:0]   result_node;
   value_type           removed_value;
   logic [COUNT_W-1:0]  list_count;

   modport source (output valid, output status, output result_node, output removed_value,
                   output list_count, input ready);
   modport sink   (input valid, input status, input result_node, input removed_value,
                   input list_count, output ready);
endinterface

`default_nettype wire

// File: rtl/blle_ram.sv
`default_nettype none

module blle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/bounded_linked_list_engine.sv
// Bounded doubly linked list (deque) over a node table.
// req channel: one beat carries an opcode (insert head, insert tail, remove head,
// remove tail, remove node), a 64-bit value for inserts and a node index for
// remove node. rsp channel: exactly one beat per request with status, node index,
// removed value and the list count after the operation.
// csr_wr_en/csr_wr_data write the list limit register; write only while idle.
// Full, empty, out-of-range node and unknown-opcode requests load the response
// register straight from idle; any other remove passes through S_READ (one
// link-table read, then the neighbor link writes), an insert into an empty list
// through S_ALLOC, and other inserts through S_ALLOC and S_FIX (free-stack read,
// new node write, neighbor write).
// req.ready is high only in the idle state, so one request is in work at a time
// and the next beat is taken only once the sequencer is back in idle.
// A stalled rsp holds its beat; a new request is taken only when the response
// register is empty or being drained in the same cycle.
// Reset empties the list and restores the list limit to 64; no clearing pass is
// run, untouched free-stack and membership entries are tracked by a low-water mark.
`default_nettype none

module bounded_linked_list_engine import blle_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   blle_req_if.sink                req,
   blle_rsp_if.source              rsp,
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ALLOC = 2'd1;
   localparam logic [1:0] S_FIX   = 2'd2;
   localparam logic [1:0] S_READ  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   value_type           value_ff, value_in;
   logic [IDX_W-1:0]    node_ff, node_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    free_top_ff, free_top_in;
   logic [CNT_W-1:0]    min_top_ff, min_top_in;
   logic [COUNT_W-1:0]  list_limit_ff, list_limit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [NODE_W-1:0]   rsp_node_ff, rsp_node_in;
   value_type           rsp_removed_ff, rsp_removed_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // table ports
   logic               next_wr_en, prev_wr_en, pay_wr_en, mark_wr_en, free_wr_en;
   logic [IDX_W-1:0]   next_wr_addr, prev_wr_addr, pay_wr_addr, mark_wr_addr, free_wr_addr;
   logic [IDX_W-1:0]   next_wr_data, prev_wr_data, free_wr_data;
   logic [VALUE_W-1:0] pay_wr_data;
   logic [0:0]         mark_wr_data;
   logic [IDX_W-1:0]   link_rd_addr, free_rd_addr;
   logic [IDX_W-1:0]   next_rd_data, prev_rd_data, free_rd_data;
   logic [VALUE_W-1:0] pay_rd_data;
   logic [0:0]         mark_rd_data;

   logic               req_fire;
   logic               list_full;
   logic [IDX_W-1:0]   alloc_node;
   logic               node_member;

   blle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_next_ram (
      .clock(clock), .wr_en(next_wr_en), .wr_addr(next_wr_addr), .wr_data(next_wr_data),
      .rd_addr(link_rd_addr), .rd_data(next_rd_data)
   );

   blle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prev_ram (
      .clock(clock), .wr_en(prev_wr_en), .wr_addr(prev_wr_addr), .wr_data(prev_wr_data),
      .rd_addr(link_rd_addr), .rd_data(prev_rd_data)
   );

   blle_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_payload_ram (
      .clock(clock), .wr_en(pay_wr_en), .wr_addr(pay_wr_addr), .wr_data(pay_wr_data),
      .rd_addr(link_rd_addr), .rd_data(pay_rd_data)
   );

   blle_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_member_ram (
      .clock(clock), .wr_en(mark_wr_en), .wr_addr(mark_wr_addr), .wr_data(mark_wr_data),
      .rd_addr(link_rd_addr), .rd_data(mark_rd_data)
   );

   blle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free_ram (
      .clock(clock), .wr_en(free_wr_en), .wr_addr(free_wr_addr), .wr_data(free_wr_data),
      .rd_addr(free_rd_addr), .rd_data(free_rd_data)
   );

   // handshake
   assign req.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign req_fire  = req.valid && req.ready;

   assign list_full = (32'(count_ff) >= 32'(list_limit_ff)) || (32'(count_ff) >= CAPACITY);

   // free-stack slots at or above the low-water mark were pushed; below it they hold
   // their own index
   assign free_rd_addr = IDX_W'(free_top_ff - 1'b1);
   assign alloc_node   = (free_top_ff == min_top_ff) ? IDX_W'(free_top_ff - 1'b1)
                                                     : free_rd_data;

   // nodes below the low-water mark were never allocated, so never in the list
   assign node_member = (CNT_W'(node_ff) >= min_top_ff) && mark_rd_data[0];

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      value_in       = value_ff;
      node_in        = node_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      free_top_in    = free_top_ff;
      min_top_in     = min_top_ff;
      list_limit_in  = csr_wr_en ? csr_wr_data : list_limit_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_node_in    = rsp_node_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_count_in   = rsp_count_ff;

      next_wr_en   = 1'b0;
      next_wr_addr = '0;
      next_wr_data = '0;
      prev_wr_en   = 1'b0;
      prev_wr_addr = '0;
      prev_wr_data = '0;
      pay_wr_en    = 1'b0;
      pay_wr_addr  = '0;
      pay_wr_data  = '0;
      mark_wr_en   = 1'b0;
      mark_wr_addr = '0;
      mark_wr_data = '0;
      free_wr_en   = 1'b0;
      free_wr_addr = '0;
      free_wr_data = '0;
      link_rd_addr = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            // pick the node a remove reads
            case (req.opcode) inside
               OP_REMOVE_TAIL: link_rd_addr = tail_ff;
               OP_REMOVE_NODE: link_rd_addr = IDX_W'(req.node_index);
               default:        link_rd_addr = head_ff;
            endcase
            if (req_fire) begin
               op_in          = req.opcode;
               value_in       = req.item_value;
               node_in        = link_rd_addr;
               rsp_status_in  = ST_OK;
               rsp_node_in    = '0;
               rsp_removed_in = '0;
               rsp_count_in   = COUNT_W'(count_ff);
               case (req.opcode) inside
                  OP_INSERT_HEAD, OP_INSERT_TAIL: begin
                     if (list_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                     end else begin
                        state_in = S_ALLOC;
                     end
                  end
                  OP_REMOVE_HEAD, OP_REMOVE_TAIL, OP_REMOVE_NODE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else if (req.opcode == OP_REMOVE_NODE &&
                                  32'(req.node_index) >= CAPACITY) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOT_IN_LIST;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         S_ALLOC: begin
            // pop the free stack, write the new node
            pay_wr_en    = 1'b1;
            pay_wr_addr  = alloc_node;
            pay_wr_data  = value_ff;
            mark_wr_en   = 1'b1;
            mark_wr_addr = alloc_node;
            mark_wr_data = 1'b1;
            next_wr_en   = 1'b1;
            next_wr_addr = alloc_node;
            prev_wr_en   = 1'b1;
            prev_wr_addr = alloc_node;
            node_in      = alloc_node;
            count_in     = CNT_W'(count_ff + 1'b1);
            free_top_in  = CNT_W'(free_top_ff - 1'b1);
            if (free_top_ff == min_top_ff) begin
               min_top_in = CNT_W'(free_top_ff - 1'b1);
            end
            if (count_ff == '0) begin
               next_wr_data   = alloc_node;
               prev_wr_data   = alloc_node;
               head_in        = alloc_node;
               tail_in        = alloc_node;
               state_in       = S_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_OK;
               rsp_node_in    = NODE_W'(alloc_node);
               rsp_removed_in = '0;
               rsp_count_in   = COUNT_W'(count_ff + 1'b1);
            end else if (op_ff == OP_INSERT_HEAD) begin
               next_wr_data = head_ff;
               prev_wr_data = alloc_node;
               state_in     = S_FIX;
            end else begin
               next_wr_data = alloc_node;
               prev_wr_data = tail_ff;
               state_in     = S_FIX;
            end
         end

         S_FIX: begin
            // link the old end to the new node
            if (op_ff == OP_INSERT_HEAD) begin
               prev_wr_en   = 1'b1;
               prev_wr_addr = head_ff;
               prev_wr_data = node_ff;
               head_in      = node_ff;
            end else begin
               next_wr_en   = 1'b1;
               next_wr_addr = tail_ff;
               next_wr_data = node_ff;
               tail_in      = node_ff;
            end
            state_in       = S_IDLE;
            rsp_valid_in   = 1'b1;
            rsp_status_in  = ST_OK;
            rsp_node_in    = NODE_W'(node_ff);
            rsp_removed_in = '0;
            rsp_count_in   = COUNT_W'(count_ff);
         end

         S_READ: begin
            // unlink the node and push it on the free stack, or answer not in list
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (!node_member) begin
               rsp_status_in  = ST_NOT_IN_LIST;
               rsp_node_in    = '0;
               rsp_removed_in = '0;
               rsp_count_in   = COUNT_W'(count_ff);
            end else begin
               if (count_ff == CNT_W'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end else if (node_ff == head_ff) begin
                  head_in      = next_rd_data;
                  prev_wr_en   = 1'b1;
                  prev_wr_addr = next_rd_data;
                  prev_wr_data = next_rd_data;
               end else if (node_ff == tail_ff) begin
                  tail_in      = prev_rd_data;
                  next_wr_en   = 1'b1;
                  next_wr_addr = prev_rd_data;
                  next_wr_data = prev_rd_data;
               end else begin
                  next_wr_en   = 1'b1;
                  next_wr_addr = prev_rd_data;
                  next_wr_data = next_rd_data;
                  prev_wr_en   = 1'b1;
                  prev_wr_addr = next_rd_data;
                  prev_wr_data = prev_rd_data;
               end
               mark_wr_en     = 1'b1;
               mark_wr_addr   = node_ff;
               mark_wr_data   = 1'b0;
               free_wr_en     = 1'b1;
               free_wr_addr   = IDX_W'(free_top_ff);
               free_wr_data   = node_ff;
               free_top_in    = CNT_W'(free_top_ff + 1'b1);
               count_in       = CNT_W'(count_ff - 1'b1);
               rsp_status_in  = ST_OK;
               rsp_node_in    = NODE_W'(node_ff);
               rsp_removed_in = pay_rd_data;
               rsp_count_in   = COUNT_W'(count_ff - 1'b1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         free_top_ff   <= CNT_W'(CAPACITY);
         min_top_ff    <= CNT_W'(CAPACITY);
         list_limit_ff <= LIST_LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         free_top_ff   <= free_top_in;
         min_top_ff    <= min_top_in;
         list_limit_ff <= list_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      value_ff       <= value_in;
      node_ff        <= node_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_node_ff    <= rsp_node_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.result_node   = rsp_node_ff;
   assign rsp.removed_value = rsp_removed_ff;
   assign rsp.list_count    = rsp_count_ff;

   // free stack and list together always account for every node
   a_node_balance: assert property (@(posedge clock) disable iff (reset)
      32'(free_top_ff) + 32'(count_ff) == CAPACITY)
      else $error("free stack depth and list count out of balance");

   // low-water mark never rises above the free-stack top
   a_low_water: assert property (@(posedge clock) disable iff (reset)
      min_top_ff <= free_top_ff)
      else $error("free stack low-water mark above top");

   // an accepted beat either answers at once or starts the sequencer
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> rsp_valid_ff || (state_ff != S_IDLE))
      else $error("request beat accepted without progress");

   // no response is pending while the sequencer is busy, apart from right after it leaves idle
   a_busy_no_stale: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff || $past(state_ff) == S_IDLE)
      else $error("response still pending while an operation runs");

   // an empty list keeps both ends at node zero
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> head_ff == '0 && tail_ff == '0)
      else $error("empty list with stale end pointers");

endmodule

`default_nettype wire

// File: tb/bounded_linked_list_engine_test.sv
`default_nettype none

module bounded_linked_list_engine_test import blle_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY    = 64;
   localparam int HOLD_CYCLES = 200;
   localparam logic [OPCODE_W-1:0] OP_FIRST_UNUSED = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_MID_UNUSED   = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_LAST_UNUSED  = 3'd7;
   localparam value_type VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      value_type           item_value;
      logic [NODE_W-1:0]   node_index;
   } list_op_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [NODE_W-1:0]   result_node;
      value_type           removed_value;
      logic [COUNT_W-1:0]  list_count;
   } list_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;

   blle_req_if req ();
   blle_rsp_if rsp ();

   bounded_linked_list_engine #(.CAPACITY(CAPACITY)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow copy of the node table
   logic [NODE_W-1:0] next_of [CAPACITY];
   logic [NODE_W-1:0] prev_of [CAPACITY];
   value_type         payload_of [CAPACITY];
   bit                linked [CAPACITY];
   logic [NODE_W-1:0] spare_nodes [CAPACITY];
   logic [NODE_W-1:0] first_node;
   logic [NODE_W-1:0] last_node;
   int unsigned       live_count;
   int unsigned       spare_top;
   int unsigned       count_limit;

   list_op_type     queued_ops [$];
   list_result_type predicted_results [$];

   int unsigned mismatches   = 0;
   int unsigned results_seen = 0;
   int unsigned req_gap      = 0;
   int unsigned rsp_stall    = 0;
   int unsigned hold_left    = 0;
   bit          idling       = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // apply one operation to the shadow list and return its result beat
   function automatic list_result_type apply_list_op(list_op_type op);
      list_result_type r;
      int unsigned  lim;
      logic [NODE_W-1:0] n;
      logic [NODE_W-1:0] nx;
      logic [NODE_W-1:0] pv;
      r = '0;
      r.status = ST_OK;
      lim = (count_limit < CAPACITY) ? count_limit : CAPACITY;
      case (op.opcode)
         OP_INSERT_HEAD, OP_INSERT_TAIL: begin
            if (live_count >= lim || spare_top == 0) begin
               r.status = ST_FULL;
            end else begin
               spare_top--;
               n = spare_nodes[spare_top];
               payload_of[n] = op.item_value;
               linked[n] = 1'b1;
               if (live_count == 0) begin
                  next_of[n] = n;
                  prev_of[n] = n;
                  first_node = n;
                  last_node  = n;
               end else if (op.opcode == OP_INSERT_HEAD) begin
                  next_of[n] = first_node;
                  prev_of[n] = n;
                  prev_of[first_node] = n;
                  first_node = n;
               end else begin
                  prev_of[n] = last_node;
                  next_of[n] = n;
                  next_of[last_node] = n;
                  last_node = n;
               end
               live_count++;
               r.result_node = n;
            end
         end
         OP_REMOVE_HEAD, OP_REMOVE_TAIL, OP_REMOVE_NODE: begin
            // empty check wins over the membership check
            if (live_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               if (op.opcode == OP_REMOVE_HEAD) n = first_node;
               else if (op.opcode == OP_REMOVE_TAIL) n = last_node;
               else n = op.node_index;
               if (!linked[n]) begin
                  r.status = ST_NOT_IN_LIST;
               end else begin
                  r.removed_value = payload_of[n];
                  r.result_node   = n;
                  nx = next_of[n];
                  pv = prev_of[n];
                  // unlink and fix the neighbors
                  if (live_count == 1) begin
                     first_node = '0;
                     last_node  = '0;
                  end else if (n == first_node) begin
                     first_node = nx;
                     prev_of[nx] = nx;
                  end else if (n == last_node) begin
                     last_node = pv;
                     next_of[pv] = pv;
                  end else begin
                     next_of[pv] = nx;
                     prev_of[nx] = pv;
                  end
                  linked[n] = 1'b0;
                  live_count--;
                  if (spare_top < CAPACITY) begin
                     spare_nodes[spare_top] = n;
                     spare_top++;
                  end
               end
            end
         end
         default: ;
      endcase
      r.list_count = live_count[COUNT_W-1:0];
      return r;
   endfunction

   // request driver: holds a beat until taken, predicts on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            predicted_results.push_back(apply_list_op(queued_ops[0]));
            queued_ops.pop_front();
         end
         if (req.valid && !req.ready) begin
            // beat stays on the bus
         end else if (req_gap != 0) begin
            req_gap--;
            req.valid <= 1'b0;
         end else if (idling && queued_ops.size() != 0 && $urandom_range(0, 3) == 0) begin
            req_gap = $urandom_range(1, 16) - 1;
            req.valid <= 1'b0;
         end else if (queued_ops.size() != 0) begin
            req.valid      <= 1'b1;
            req.opcode     <= queued_ops[0].opcode;
            req.item_value <= queued_ops[0].item_value;
            req.node_index <= queued_ops[0].node_index;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // result monitor: compares each beat with the oldest prediction
   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (predicted_results.size() == 0) begin
               $display({"%0t: result beat expected none actual status %0d node %0d",
                         " value %0d count %0d"},
                        $time, rsp.status, rsp.result_node, rsp.removed_value, rsp.list_count);
               mismatches++;
            end else begin
               want = predicted_results.pop_front();
               if (rsp.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp.status);
                  mismatches++;
               end
               if (rsp.result_node !== want.result_node) begin
                  $display("%0t: result_node expected %0d actual %0d",
                           $time, want.result_node, rsp.result_node);
                  mismatches++;
               end
               if (rsp.removed_value !== want.removed_value) begin
                  $display("%0t: removed_value expected %0d actual %0d",
                           $time, want.removed_value, rsp.removed_value);
                  mismatches++;
               end
               if (rsp.list_count !== want.list_count) begin
                  $display("%0t: list_count expected %0d actual %0d",
                           $time, want.list_count, rsp.list_count);
                  mismatches++;
               end
            end
            results_seen++;
            // long back-pressure so the engine backs up into its input
            if (results_seen == 300 || results_seen == 1000) hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else if (rsp_stall != 0) begin
            rsp_stall--;
            rsp.ready <= 1'b0;
         end else if (idling && $urandom_range(0, 3) == 0) begin
            rsp_stall = $urandom_range(1, 16) - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   task automatic queue_op(logic [OPCODE_W-1:0] opc, value_type v, logic [NODE_W-1:0] idx);
      list_op_type op;
      op.opcode     = opc;
      op.item_value = v;
      op.node_index = idx;
      queued_ops.push_back(op);
   endtask

   function automatic value_type random_value();
      case ($urandom_range(0, 7))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2: return '0;
         3: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // wait for the engine to go idle, then write the list limit
   task automatic set_limit(logic [COUNT_W-1:0] v);
      while (queued_ops.size() != 0 || predicted_results.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      count_limit = 32'(v);
   endtask

   // random traffic; remove node mostly aims at a node that is linked
   task automatic run_random(int unsigned n, int unsigned insert_pct);
      int unsigned       roll;
      int unsigned       pick;
      logic [OPCODE_W-1:0] opc;
      logic [NODE_W-1:0] idx;
      for (int unsigned i = 0; i < n; i++) begin
         while (queued_ops.size() >= 2) @(posedge clock);
         roll = $urandom_range(0, 99);
         idx  = NODE_W'($urandom_range(0, CAPACITY - 1));
         if (roll < 4) begin
            opc = OPCODE_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
         end else if (roll < 4 + insert_pct) begin
            opc = $urandom_range(0, 1) ? OP_INSERT_TAIL : OP_INSERT_HEAD;
         end else begin
            case ($urandom_range(0, 2))
               0: opc = OP_REMOVE_HEAD;
               1: opc = OP_REMOVE_TAIL;
               default: opc = OP_REMOVE_NODE;
            endcase
            if (live_count != 0 && $urandom_range(0, 3) != 0) begin
               pick = $urandom_range(0, CAPACITY - 1);
               while (!linked[pick]) pick = (pick + 1) % CAPACITY;
               idx = NODE_W'(pick);
            end
         end
         queue_op(opc, random_value(), idx);
      end
   endtask

   initial begin
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req.valid      = 1'b0;
      req.opcode     = OP_INSERT_HEAD;
      req.item_value = '0;
      req.node_index = '0;
      rsp.ready      = 1'b0;

      // shadow list after reset
      for (int i = 0; i < CAPACITY; i++) begin
         next_of[i]     = '0;
         prev_of[i]     = '0;
         payload_of[i]  = '0;
         linked[i]      = 1'b0;
         spare_nodes[i] = NODE_W'(i);
      end
      first_node  = '0;
      last_node   = '0;
      live_count  = 0;
      spare_top   = CAPACITY;
      count_limit = 32'(LIST_LIMIT_RESET);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // removes on an empty list, then both ends and the middle
      queue_op(OP_REMOVE_HEAD, 64'h5555_5555_5555_5555, '0);
      queue_op(OP_REMOVE_TAIL, '0, '1);
      queue_op(OP_REMOVE_NODE, '0, '0);
      queue_op(OP_INSERT_HEAD, VALUE_MAX, '1);
      queue_op(OP_INSERT_TAIL, VALUE_MIN, '0);
      queue_op(OP_INSERT_HEAD, '1, 6'd21);
      queue_op(OP_INSERT_TAIL, '0, 6'd42);
      queue_op(OP_REMOVE_NODE, '0, '0);
      queue_op(OP_REMOVE_NODE, 64'hAAAA_AAAA_AAAA_AAAA, 6'd62);
      queue_op(OP_FIRST_UNUSED, 64'h1234_5678_9ABC_DEF0, 6'd63);
      queue_op(OP_MID_UNUSED, '1, 6'd1);
      queue_op(OP_LAST_UNUSED, VALUE_MIN, 6'd62);
      queue_op(OP_REMOVE_TAIL, '0, '0);
      queue_op(OP_REMOVE_HEAD, '0, '0);
      queue_op(OP_REMOVE_NODE, '0, 6'd63);
      queue_op(OP_REMOVE_NODE, '0, 6'd63);

      // zero limit: every insert is full
      set_limit('0);
      queue_op(OP_INSERT_HEAD, 64'hDEAD_BEEF_0000_0001, '0);
      queue_op(OP_INSERT_TAIL, VALUE_MAX, '1);
      queue_op(OP_REMOVE_TAIL, '0, '0);

      // limit of one
      set_limit(7'd1);
      queue_op(OP_INSERT_TAIL, 64'h0F0F_F0F0_0F0F_F0F0, '0);
      queue_op(OP_INSERT_HEAD, VALUE_MIN, '0);
      queue_op(OP_REMOVE_NODE, '0, '0);
      queue_op(OP_REMOVE_HEAD, '0, '0);

      // random phases over several limits
      set_limit(7'd64);
      run_random(150, 50);
      set_limit(7'd3);
      run_random(150, 50);
      set_limit(7'd64);
      run_random(220, 75);
      set_limit(7'd21);
      run_random(150, 45);
      set_limit(7'd1);
      run_random(120, 50);
      set_limit(COUNT_W'($urandom_range(0, 64)));
      run_random(150, 50);
      set_limit(7'd40);
      run_random(150, 55);
      set_limit(7'd2);
      run_random(100, 50);

      // closing stretch at full rate
      idling = 1'b0;
      set_limit('0);
      run_random(60, 50);
      set_limit(7'd64);
      run_random(250, 60);

      while (queued_ops.size() != 0 || predicted_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(5_000_000);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
rtl/blle_pkg.sv
rtl/blle_req_if.sv
rtl/blle_rsp_if.sv
rtl/blle_ram.sv
rtl/bounded_linked_list_engine.sv
tb/bounded_linked_list_engine_test.sv
